### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the cycle counter rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// types and constants of the simple cycle counter
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int CNT_W  = 64;
    localparam int OUT_W  = 63;
    localparam int VTX_W  = 4;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0] NV_RESET     = 4'd12;
    localparam logic             MODE_EDGE    = 1'b0;
    localparam logic             MODE_COMPUTE = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SET   = 9'b000000010,
        S_J     = 9'b000000100,
        S_ACC   = 9'b000001000,
        S_DRAIN = 9'b000010000,
        S_WRITE = 9'b000100000,
        S_TOTAL = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_HOLD  = 9'b100000000
    } t_state;

    // controls of the shared accumulate unit
    typedef struct packed {
        logic clr_sum;
        logic one_sum;
        logic add_rd;
        logic add_total;
        logic clr_total;
    } t_acc_ctl;

endpackage

### src/scc_mem.sv
// ----------------------------------------------------------------------------
// scc_mem
// path count store, one write port and one registered read port
// ----------------------------------------------------------------------------
module scc_mem #(
    parameter int DEPTH = 49152,
    parameter int AW    = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [scc_pkg::CNT_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [scc_pkg::CNT_W-1:0]  o_rdata
);

    logic [scc_pkg::CNT_W-1:0] r_mem [DEPTH];
    logic [scc_pkg::CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/scc_acc.sv
// ----------------------------------------------------------------------------
// scc_acc
// shared 64-bit adder with the path sum and cycle total accumulators
// ----------------------------------------------------------------------------
module scc_acc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  scc_pkg::t_acc_ctl          i_ctl,
    input  logic [scc_pkg::CNT_W-1:0]  i_rdata,
    output logic [scc_pkg::CNT_W-1:0]  o_sum,
    output logic [scc_pkg::CNT_W-1:0]  o_total
);

    logic [scc_pkg::CNT_W-1:0] r_sum;
    logic [scc_pkg::CNT_W-1:0] n_sum;
    logic [scc_pkg::CNT_W-1:0] r_total;
    logic [scc_pkg::CNT_W-1:0] n_total;
    logic [scc_pkg::CNT_W-1:0] w_op_a;
    logic [scc_pkg::CNT_W-1:0] w_op_b;
    logic [scc_pkg::CNT_W-1:0] w_add;

    assign w_op_a = i_ctl.add_total ? r_total : r_sum;
    assign w_op_b = i_ctl.add_total ? r_sum : i_rdata;
    assign w_add  = w_op_a + w_op_b;

    always_comb begin
        n_sum   = r_sum;
        n_total = r_total;
        if (i_ctl.clr_sum) begin
            n_sum = '0;
        end else if (i_ctl.one_sum) begin
            n_sum = scc_pkg::CNT_W'(1);
        end else if (i_ctl.add_rd) begin
            n_sum = w_add;
        end
        if (i_ctl.clr_total) begin
            n_total = '0;
        end else if (i_ctl.add_total) begin
            n_total = w_add;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    assign o_sum   = r_sum;
    assign o_total = r_total;

endmodule

### src/simple_cycle_counter.sv
// ----------------------------------------------------------------------------
// simple_cycle_counter
// counts simple cycles of length three or more in an undirected graph
// ----------------------------------------------------------------------------
// Edge items (tuser 0) are taken whenever the block is idle, also while a
// count waits on the output. A compute item (tuser 1) walks every nonempty
// vertex subset of the n active vertices: per subset a setup step, per vertex
// a check step and a step to the next vertex, and for a path end that is not
// the subset's top vertex a read step per active vertex, a drain step and a
// write step, plus a total step when the path closes; a lone vertex or the top
// vertex goes straight to the write step. The walk is serialised by the single
// read port of the path count memory and the one shared 64-bit adder; the
// input is not ready during the walk. The count is then posted and the graph
// cleared.
`include "assert_macros.svh"

module simple_cycle_counter #(
    parameter int MAX_VERTICES = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scc_pkg::CFG_W-1:0]   i_cfg_wdata,     // num_vertices
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,  // vertex_a, vertex_b
    input  logic [0:0]                  i_s_axis_tuser,  // mode
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [63:0]                 o_m_axis_tdata   // cycle_count, zero pad
);

    localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = (2 ** MAX_VERTICES) * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [MAX_VERTICES-1:0] ONE_SET = MAX_VERTICES'(1);

    scc_pkg::t_state             r_state;
    scc_pkg::t_state             n_state;
    logic [scc_pkg::CFG_W-1:0]   r_num_vertices;
    logic [MAX_VERTICES-1:0]     r_adj [MAX_VERTICES];
    logic [NW-1:0]               r_n;
    logic [MAX_VERTICES-1:0]     r_set;
    logic [VW-1:0]               r_top;
    logic [NW-1:0]               r_size;
    logic [VW-1:0]               r_j;
    logic [VW-1:0]               r_k;
    logic [MAX_VERTICES-1:0]     r_near;
    logic [AW-1:0]               r_base;
    logic [AW-1:0]               r_set_base;
    logic                        r_rd_vld;
    logic                        r_out_valid;
    logic [scc_pkg::OUT_W-1:0]   r_out_data;

    logic [NW-1:0]               w_eff_n;
    logic [MAX_VERTICES-1:0]     w_keep;
    logic [MAX_VERTICES-1:0]     w_rest;
    logic                        w_last_j;
    logic                        w_last_set;
    logic                        w_last_k;
    logic                        w_in_fire;
    logic                        w_out_fire;
    logic [VW-1:0]               w_a;
    logic [VW-1:0]               w_b;
    logic                        w_edge_ok;
    logic                        w_close;
    scc_pkg::t_acc_ctl           w_ctl;
    logic                        w_re;
    logic [AW-1:0]               w_raddr;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [scc_pkg::CNT_W-1:0]   w_rdata;
    logic [scc_pkg::CNT_W-1:0]   w_sum;
    logic [scc_pkg::CNT_W-1:0]   w_total;

    function automatic logic [VW-1:0] f_top(input logic [MAX_VERTICES-1:0] s);
        logic [VW-1:0] t;
        t = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (s[i]) begin
                t = VW'(i);
            end
        end
        return t;
    endfunction

    function automatic logic [NW-1:0] f_size(input logic [MAX_VERTICES-1:0] s);
        logic [NW-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            c = c + NW'(s[i]);
        end
        return c;
    endfunction

    // effective vertex count
    always_comb begin
        if (r_num_vertices == '0) begin
            w_eff_n = NW'(1);
        end else if (32'(r_num_vertices) > MAX_VERTICES) begin
            w_eff_n = NW'(MAX_VERTICES);
        end else begin
            w_eff_n = NW'(r_num_vertices);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_keep[i] = (NW'(i) < r_n);
        end
    end

    assign w_rest     = r_set & ~(ONE_SET << r_j);
    assign w_last_j   = (NW'(r_j) + NW'(1)) == r_n;
    assign w_last_k   = (NW'(r_k) + NW'(1)) == r_n;
    assign w_last_set = (r_set == w_keep);
    assign w_close    = (r_size >= NW'(3)) && r_adj[r_j][r_top];

    assign o_s_axis_tready = (r_state == scc_pkg::S_IDLE);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_fire      = (r_state == scc_pkg::S_DONE)
                             && (!r_out_valid || i_m_axis_tready);

    assign w_a       = VW'(i_s_axis_tdata[3:0]);
    assign w_b       = VW'(i_s_axis_tdata[7:4]);
    assign w_edge_ok = (i_s_axis_tdata[3:0] != i_s_axis_tdata[7:4])
                       && (32'(i_s_axis_tdata[3:0]) < 32'(w_eff_n))
                       && (32'(i_s_axis_tdata[7:4]) < 32'(w_eff_n));

    assign w_re    = (r_state == scc_pkg::S_ACC) && r_near[r_k];
    assign w_raddr = r_base + AW'(r_k);
    assign w_we    = (r_state == scc_pkg::S_WRITE);
    assign w_waddr = r_set_base + AW'(r_j);

    always_comb begin
        n_state         = r_state;
        w_ctl           = '0;
        case (r_state)
            scc_pkg::S_IDLE: begin
                if (w_in_fire && i_s_axis_tuser[0] == scc_pkg::MODE_COMPUTE) begin
                    w_ctl.clr_total = 1'b1;
                    n_state         = scc_pkg::S_SET;
                end
            end
            scc_pkg::S_SET: begin
                n_state = scc_pkg::S_J;
            end
            scc_pkg::S_J: begin
                if (!r_set[r_j]) begin
                    n_state = scc_pkg::S_HOLD;
                end else if (r_size == NW'(1)) begin
                    w_ctl.one_sum = 1'b1;
                    n_state       = scc_pkg::S_WRITE;
                end else if (r_j == r_top) begin
                    w_ctl.clr_sum = 1'b1;
                    n_state       = scc_pkg::S_WRITE;
                end else begin
                    w_ctl.clr_sum = 1'b1;
                    n_state       = scc_pkg::S_ACC;
                end
            end
            scc_pkg::S_ACC: begin
                w_ctl.add_rd = r_rd_vld;
                if (w_last_k) begin
                    n_state = scc_pkg::S_DRAIN;
                end
            end
            scc_pkg::S_DRAIN: begin
                w_ctl.add_rd = r_rd_vld;
                n_state      = scc_pkg::S_WRITE;
            end
            scc_pkg::S_WRITE: begin
                n_state = w_close ? scc_pkg::S_TOTAL : scc_pkg::S_HOLD;
            end
            scc_pkg::S_TOTAL: begin
                w_ctl.add_total = 1'b1;
                n_state         = scc_pkg::S_HOLD;
            end
            scc_pkg::S_HOLD: begin
                // step to the next vertex or subset, or to done after the last subset
                if (!w_last_j) begin
                    n_state = scc_pkg::S_J;
                end else if (w_last_set) begin
                    n_state = scc_pkg::S_DONE;
                end else begin
                    n_state = scc_pkg::S_SET;
                end
            end
            scc_pkg::S_DONE: begin
                if (w_out_fire) begin
                    n_state = scc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= scc_pkg::S_IDLE;
            r_num_vertices <= scc_pkg::NV_RESET;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_adj[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_re;
            if (i_cfg_we) begin
                r_num_vertices <= i_cfg_wdata;
            end
            if (w_in_fire && i_s_axis_tuser[0] == scc_pkg::MODE_EDGE && w_edge_ok) begin
                r_adj[w_a][w_b] <= 1'b1;
                r_adj[w_b][w_a] <= 1'b1;
            end
            if (w_out_fire) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    r_adj[i] <= '0;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sequencer datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            scc_pkg::S_IDLE: begin
                r_n   <= w_eff_n;
                r_set <= ONE_SET;
            end
            scc_pkg::S_SET: begin
                r_top      <= f_top(r_set);
                r_size     <= f_size(r_set);
                r_set_base <= AW'(32'(r_set) * MAX_VERTICES);
                r_j        <= '0;
            end
            scc_pkg::S_J: begin
                r_near <= r_adj[r_j] & w_keep & w_rest;
                r_base <= AW'(32'(w_rest) * MAX_VERTICES);
                r_k    <= '0;
            end
            scc_pkg::S_ACC: begin
                r_k <= r_k + VW'(1);
            end
            scc_pkg::S_HOLD: begin
                if (!w_last_j) begin
                    r_j <= r_j + VW'(1);
                end else begin
                    r_set <= r_set + ONE_SET;
                end
            end
            scc_pkg::S_DONE: begin
                if (w_out_fire) begin
                    r_out_data <= w_total[scc_pkg::CNT_W-1:1];
                end
            end
            default: begin
            end
        endcase
    end

    scc_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_sum),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    scc_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rdata (w_rdata),
        .o_sum   (w_sum),
        .o_total (w_total)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_data};

    `SCC_ASSERT_IMP(a_out_from_done, $rose(r_out_valid), $past(r_state == scc_pkg::S_DONE), "count posted outside done")
    `SCC_ASSERT_IMP(a_write_in_set, r_state == scc_pkg::S_WRITE, r_set[r_j] == 1'b1, "path entry written for vertex outside subset")
    `SCC_ASSERT_IMP(a_total_even, r_state == scc_pkg::S_DONE, w_total[0] == 1'b0, "cycle total is odd")
    `SCC_ASSERT_NXT(a_compute_start, w_in_fire && i_s_axis_tuser[0] == scc_pkg::MODE_COMPUTE, r_state == scc_pkg::S_SET, "compute item did not start walk")

endmodule

### test/simple_cycle_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_cycle_counter_tb
// edge loading and cycle counting of the simple cycle counter
// ----------------------------------------------------------------------------
// Edge and compute items go in through the slave stream with random gaps and
// the counts come back through the master stream under random stalls. A
// local graph copy is updated per accepted item, and each compute item runs
// the subset path dynamic program in the bench so that every posted count
// is compared in order. Directed graphs cover the reset vertex count,
// self-loops, duplicates, out-of-range endpoints and vertex count changes;
// random rounds of edges and counts over small vertex counts follow.
// ----------------------------------------------------------------------------
module simple_cycle_counter_tb;

    localparam int MAX_V         = 12;
    localparam int CFG_W         = scc_pkg::CFG_W;
    localparam int OUT_W         = scc_pkg::OUT_W;
    localparam int VTX_W         = scc_pkg::VTX_W;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int RUN_LIMIT_NS  = 200_000_000;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_we        = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata     = '0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [7:0]       i_s_axis_tdata  = '0;   // vertex_a, vertex_b
    logic [0:0]       i_s_axis_tuser  = '0;   // mode
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [63:0]      o_m_axis_tdata;         // cycle_count, zero pad

    simple_cycle_counter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // graph copy and count table
    logic [MAX_V-1:0] adj_rows [MAX_V];
    logic [CFG_W-1:0] nv_reg = scc_pkg::NV_RESET;
    logic [63:0]      path_tab [1 << MAX_V][MAX_V];
    logic [OUT_W-1:0] expected_counts [$];
    logic [OUT_W-1:0] want;
    int               failures = 0;
    bit               no_gaps  = 1'b0;

    initial begin
        foreach (adj_rows[r]) adj_rows[r] = '0;
    end

    function automatic int active_vertices();
        if (nv_reg == 0) return 1;
        if (nv_reg > MAX_V) return MAX_V;
        return int'(nv_reg);
    endfunction

    function automatic logic [OUT_W-1:0] tally_cycles(input int n);
        logic [63:0]      total;
        logic [63:0]      sum;
        logic [MAX_V-1:0] keep;
        logic [MAX_V-1:0] near;
        int               subset;
        int               rest;
        int               top;
        int               size;
        int               v;
        int               j;
        int               k;
        total = '0;
        keep  = MAX_V'((1 << n) - 1);
        for (subset = 1; subset < (1 << n); subset++) begin
            top = 0;
            for (v = 0; v < MAX_V; v++)
                if (subset[v]) top = v;
            size = $countones(subset);
            for (j = 0; j < n; j++) begin
                sum = '0;
                if (subset[j]) begin
                    if (size == 1) begin
                        sum = 64'd1;
                    end else if (j != top) begin
                        rest = subset ^ (1 << j);
                        near = adj_rows[j] & keep & MAX_V'(rest);
                        for (k = 0; k < n; k++)
                            if (near[k]) sum += path_tab[rest][k];
                    end
                end
                path_tab[subset][j] = sum;
                if (size >= 3 && adj_rows[j][top] && top < n) total += sum;
            end
        end
        return total[63:1];
    endfunction

    function automatic void apply_item(input logic mode, input logic [VTX_W-1:0] a,
                                       input logic [VTX_W-1:0] b);
        int n;
        n = active_vertices();
        if (mode == scc_pkg::MODE_EDGE) begin
            if (a != b && a < n && b < n) begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
            end
        end else begin
            expected_counts.push_back(tally_cycles(n));
            foreach (adj_rows[r]) adj_rows[r] = '0;
        end
    endfunction

    function automatic int draw_gap();
        if (no_gaps) return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic send_item(input logic mode, input logic [VTX_W-1:0] a,
                             input logic [VTX_W-1:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= {b, a};
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_item(mode, a, b);
    endtask

    // wait until every count is back and the block has gone quiet
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        nv_reg = value;
    endtask

    // result side stalls
    initial begin : sink_ready
        int gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_counts.size() == 0) begin
                $error("cycle_count expected none actual %0d",
                       o_m_axis_tdata[OUT_W-1:0]);
                failures++;
            end else begin
                want = expected_counts.pop_front();
                if (o_m_axis_tdata[OUT_W-1:0] !== want) begin
                    $error("cycle_count expected %0d actual %0d", want,
                           o_m_axis_tdata[OUT_W-1:0]);
                    failures++;
                end
            end
        end
    end

    // full vertex count from reset: a triangle, a square with a chord,
    // a self-loop, a duplicate and endpoints past the last vertex
    task automatic test_reset_graph();
        send_item(scc_pkg::MODE_EDGE, 4'd0, 4'd11);
        send_item(scc_pkg::MODE_EDGE, 4'd11, 4'd5);
        send_item(scc_pkg::MODE_EDGE, 4'd5, 4'd0);
        send_item(scc_pkg::MODE_EDGE, 4'd3, 4'd3);
        send_item(scc_pkg::MODE_EDGE, 4'd11, 4'd0);
        send_item(scc_pkg::MODE_EDGE, 4'd15, 4'd2);
        send_item(scc_pkg::MODE_EDGE, 4'd4, 4'd12);
        send_item(scc_pkg::MODE_EDGE, 4'd6, 4'd7);
        send_item(scc_pkg::MODE_EDGE, 4'd7, 4'd8);
        send_item(scc_pkg::MODE_EDGE, 4'd8, 4'd9);
        send_item(scc_pkg::MODE_EDGE, 4'd9, 4'd6);
        send_item(scc_pkg::MODE_EDGE, 4'd6, 4'd8);
        send_item(scc_pkg::MODE_COMPUTE, 4'd15, 4'd15);
    endtask

    // zero vertex count acts as one vertex
    task automatic test_single_vertex();
        settle();
        write_config(4'd0);
        send_item(scc_pkg::MODE_EDGE, 4'd0, 4'd1);
        send_item(scc_pkg::MODE_COMPUTE, 4'd0, 4'd0);
    endtask

    // count above the maximum, then lowered below an edge endpoint
    task automatic test_count_lowered();
        settle();
        write_config(4'd15);
        send_item(scc_pkg::MODE_EDGE, 4'd0, 4'd1);
        send_item(scc_pkg::MODE_EDGE, 4'd1, 4'd2);
        send_item(scc_pkg::MODE_EDGE, 4'd2, 4'd0);
        send_item(scc_pkg::MODE_EDGE, 4'd2, 4'd11);
        send_item(scc_pkg::MODE_EDGE, 4'd13, 4'd1);
        settle();
        write_config(4'd5);
        send_item(scc_pkg::MODE_COMPUTE, 4'd10, 4'd5);
    endtask

    function automatic logic [CFG_W-1:0] pick_vertex_count();
        int r;
        r = $urandom_range(0, 31);
        if (r < 2) return CFG_W'($urandom_range(0, 2));
        if (r == 2) return 4'd8;
        if (r < 6) return 4'd7;
        if (r < 14) return 4'd6;
        return CFG_W'($urandom_range(3, 5));
    endfunction

    task automatic test_random_graphs();
        int               counted;
        int               n;
        int               edges;
        int               i;
        int               kind;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 1) begin
                settle();
                write_config(pick_vertex_count());
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            n     = active_vertices();
            edges = $urandom_range(0, n * n);
            for (i = 0; i < edges; i++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    a = VTX_W'($urandom_range(0, 15));
                    b = VTX_W'($urandom_range(0, 15));
                end else if (kind == 1) begin
                    a = VTX_W'($urandom_range(0, n - 1));
                    b = a;
                end else begin
                    a = VTX_W'($urandom_range(0, n - 1));
                    b = VTX_W'($urandom_range(0, n - 1));
                end
                send_item(scc_pkg::MODE_EDGE, a, b);
                counted++;
            end
            // now and then the graph is carried into the next round
            if ($urandom_range(0, 15) != 0) begin
                send_item(scc_pkg::MODE_COMPUTE, VTX_W'($urandom_range(0, 15)),
                          VTX_W'($urandom_range(0, 15)));
                counted++;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin : run
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_graph();
        test_single_vertex();
        test_count_lowered();
        test_random_graphs();
        settle();
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
